// ===== src/rsqs_pkg.sv =====
package rsqs_pkg;

    // Sizes fixed by the record and result formats
    localparam int DEPTH_DEF = 64;
    localparam int MODE_W    = 2;
    localparam int KEY_W     = 32;
    localparam int YEAR_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;

    // Operation codes carried in the mode field
    typedef enum logic [MODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One stored record
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [YEAR_W-1:0]       year;
    } t_rec;

    // One result item
    typedef struct packed {
        t_status              status;
        logic                 found;
        logic [YEAR_W-1:0]    found_year;
        logic [COUNT_W-1:0]   entry_count;
    } t_res;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

endpackage

// ===== src/rsqs_if.sv =====
// Operation channel
interface rsqs_in_if import rsqs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic signed [KEY_W-1:0] key;
    logic [YEAR_W-1:0]       year;

    modport source (output valid, mode, key, year, input ready);
    modport sink   (input valid, mode, key, year, output ready);
endinterface

// Result channel
interface rsqs_out_if import rsqs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic                 found;
    logic [YEAR_W-1:0]    found_year;
    logic [COUNT_W-1:0]   entry_count;

    modport source (output valid, status, found, found_year, entry_count, input ready);
    modport sink   (input valid, status, found, found_year, entry_count, output ready);
endinterface

// ===== src/rsqs_store.sv =====
module rsqs_store import rsqs_pkg::*; #(
    parameter int  DEPTH = DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_rec          i_wr_rec,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_rec          o_rd_rec
);

    t_rec r_mem [DEPTH];
    t_rec r_rd_rec;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_rec;
        end
    end

    // Single read port, registered data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_rec <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_rec = r_rd_rec;

endmodule

// ===== src/rsqs_ctrl.sv =====
module rsqs_ctrl import rsqs_pkg::*; #(
    parameter int  DEPTH = DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    rsqs_in_if.sink       i_in,
    rsqs_out_if.source    o_out,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output t_rec          o_wr_rec,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  t_rec          i_rd_rec
);

    localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);

    // Control state
    t_state          r_state,  n_state;
    logic            r_qmode,  n_qmode;
    logic [AW-1:0]   r_oldest, n_oldest;
    logic [CW-1:0]   r_count,  n_count;
    logic [CW-1:0]   r_left,   n_left;
    logic            r_pend,   n_pend;
    logic            r_out_vld, n_out_vld;

    // Payload
    t_op                     r_op,     n_op;
    logic signed [KEY_W-1:0] r_key,    n_key;
    logic [YEAR_W-1:0]       r_year,   n_year;
    t_status                 r_status, n_status;
    logic                    r_found,  n_found;
    logic [YEAR_W-1:0]       r_fyear,  n_fyear;
    t_res                    r_out,    n_out;

    logic [AW:0]   ins_sum;
    logic [AW:0]   rd_sum;
    logic [AW-1:0] ins_pos;
    logic [AW-1:0] rd_pos;
    logic [AW-1:0] oldest_inc;
    logic          in_xfer;
    logic          out_free;

    // Ring positions: sums stay below twice the depth, one subtract wraps them
    always_comb begin
        ins_sum    = {1'b0, r_oldest} + (AW+1)'(r_count);
        ins_pos    = (ins_sum >= DEPTH_W) ? AW'(ins_sum - DEPTH_W) : AW'(ins_sum);
        rd_sum     = {1'b0, r_oldest} + (AW+1)'(r_left - 1'b1);
        rd_pos     = (rd_sum >= DEPTH_W) ? AW'(rd_sum - DEPTH_W) : AW'(rd_sum);
        oldest_inc = (r_oldest == LAST_IX) ? '0 : r_oldest + 1'b1;
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_vld || o_out.ready;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_qmode   = r_qmode;
        n_oldest  = r_oldest;
        n_count   = r_count;
        n_left    = r_left;
        n_pend    = r_pend;
        n_out_vld = r_out_vld;
        n_op      = r_op;
        n_key     = r_key;
        n_year    = r_year;
        n_status  = r_status;
        n_found   = r_found;
        n_fyear   = r_fyear;
        n_out     = r_out;
        o_wr_en   = 1'b0;
        o_rd_en   = 1'b0;

        if (i_cfg_wr_en) begin
            n_qmode = i_cfg_wr_data;
        end

        // Result taken downstream
        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op    = t_op'(i_in.mode);
                    n_key   = i_in.key;
                    n_year  = i_in.year;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_found  = 1'b0;
                n_fyear  = '0;
                n_state  = S_FIN;
                unique case (r_op)
                    OP_INSERT: begin
                        if (r_count == DEPTH_C) begin
                            n_status = ST_FULL;
                        end else begin
                            o_wr_en = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            if (r_qmode) begin
                                n_oldest = oldest_inc;
                            end
                            n_count = r_count - 1'b1;
                        end
                    end
                    OP_SEARCH: begin
                        n_left  = r_count;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end
                    OP_NOP: begin
                    end
                    default: begin
                    end
                endcase
            end
            // Newest to oldest: read one entry a cycle, compare the one read before
            S_SCAN: begin
                priority if (r_pend && (i_rd_rec.key == r_key)) begin
                    n_found = 1'b1;
                    n_fyear = i_rd_rec.year;
                    n_pend  = 1'b0;
                    n_state = S_FIN;
                end else if (r_left != '0) begin
                    o_rd_en = 1'b1;
                    n_left  = r_left - 1'b1;
                    n_pend  = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_vld         = 1'b1;
                    n_out.status      = r_status;
                    n_out.found       = r_found;
                    n_out.found_year  = r_fyear;
                    n_out.entry_count = COUNT_W'(r_count);
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Store port drive
    assign o_wr_addr     = ins_pos;
    assign o_wr_rec.key  = r_key;
    assign o_wr_rec.year = r_year;
    assign o_rd_addr     = rd_pos;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_qmode   <= 1'b0;
            r_oldest  <= '0;
            r_count   <= '0;
            r_left    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_qmode   <= n_qmode;
            r_oldest  <= n_oldest;
            r_count   <= n_count;
            r_left    <= n_left;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_year   <= n_year;
        r_status <= n_status;
        r_found  <= n_found;
        r_fyear  <= n_fyear;
        r_out    <= n_out;
    end

    // Result channel
    assign o_out.valid       = r_out_vld;
    assign o_out.status      = r_out.status;
    assign o_out.found       = r_out.found;
    assign o_out.found_year  = r_out.found_year;
    assign o_out.entry_count = r_out.entry_count;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("record count above depth");

    a_write_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_count < DEPTH_C))
        else $error("store written while full");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_op == OP_INSERT && r_count == DEPTH_C) |=> $stable(r_count))
        else $error("count moved on refused insert");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_FIN))
        else $error("result raised outside finish state");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.found) |-> (r_out.status == ST_OK))
        else $error("hit reported with bad status");

endmodule

// ===== src/record_stack_queue_with_search_core.sv =====
// Channel   Port                        Direction  Transfer when
// ops       i_in (mode, key, year)      in         i_in.valid && i_in.ready
// results   o_out (status, found, ...)  out        o_out.valid && o_out.ready
// config    i_cfg_wr_en, i_cfg_wr_data  in         i_cfg_wr_en high
//
// One operation at a time. Insert, remove and no-op pass through the execute and
// finish states before result valid rises; a search scans the records held, newest
// first, through the one-read-per-cycle port of the record memory (a hit ends it early).
// i_in.ready returns as result valid rises, so a new operation waits for the last.
// A stalled result holds the sequencer in its finish state; i_in.ready stays
// low until the result register is free again.
// Reset clears the count and ring pointer; the memory is not cleared.
module record_stack_queue_with_search_core import rsqs_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    rsqs_in_if.sink    i_in,
    rsqs_out_if.source o_out
);

    localparam int AW = $clog2(DEPTH);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_rec          wr_rec;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_rec          rd_rec;

    // Sequencer with the compare unit
    rsqs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .o_out         (o_out),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_rec      (wr_rec),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_rec      (rd_rec)
    );

    // Record memory
    rsqs_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_rec  (wr_rec),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_rec  (rd_rec)
    );

endmodule

// ===== tb/rsqs_result_check.sv =====
`timescale 1ns / 1ps

// Watches the operation and result channels, keeps its own copy of the record
// ring and compares every result transfer with the oldest predicted result.
module rsqs_result_check import rsqs_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    rsqs_in_if   in_if,
    rsqs_out_if  out_if,
    output int   o_mismatches,
    output int   o_pending
);

    // Shadow of the record ring
    logic [KEY_W-1:0]  key_mem  [DEPTH];
    logic [YEAR_W-1:0] year_mem [DEPTH];
    int                oldest_pos;
    int                held;
    logic              fifo_mode;

    // Results still owed by the block, oldest first
    t_res pending_res_q[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        oldest_pos   = 0;
        held         = 0;
        fifo_mode    = 1'b0;
    end

    // Applies one operation to the shadow ring and returns the result it owes
    function automatic t_res apply_op(t_op op, logic [KEY_W-1:0] key, logic [YEAR_W-1:0] year);
        t_res res;
        int   pos;
        res = '{status: ST_OK, found: 1'b0, found_year: '0, entry_count: '0};
        case (op)
            OP_INSERT: begin
                if (held >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos           = (oldest_pos + held) % DEPTH;
                    key_mem[pos]  = key;
                    year_mem[pos] = year;
                    held++;
                end
            end
            OP_REMOVE: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // queue mode drops the oldest, stack mode the newest
                    if (fifo_mode)
                        oldest_pos = (oldest_pos + 1) % DEPTH;
                    held--;
                end
            end
            OP_SEARCH: begin
                // newest first, first match wins
                for (int i = held - 1; i >= 0; i--) begin
                    pos = (oldest_pos + i) % DEPTH;
                    if (key_mem[pos] == key) begin
                        res.found      = 1'b1;
                        res.found_year = year_mem[pos];
                        break;
                    end
                end
            end
            default: ;
        endcase
        res.entry_count = held[COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            oldest_pos = 0;
            held       = 0;
            fifo_mode  = 1'b0;
            pending_res_q.delete();
        end else begin
            if (i_cfg_wr_en)
                fifo_mode = i_cfg_wr_data;

            // operation transfer: predict its result
            if (in_if.valid && in_if.ready)
                pending_res_q.push_back(apply_op(t_op'(in_if.mode), in_if.key, in_if.year));

            // result transfer: compare with the oldest prediction
            if (out_if.valid && out_if.ready) begin
                if (pending_res_q.size() == 0) begin
                    $error("result transfer with no operation outstanding");
                    o_mismatches++;
                end else begin
                    want = pending_res_q.pop_front();
                    if (out_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_if.status);
                        o_mismatches++;
                    end
                    if (out_if.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, out_if.found);
                        o_mismatches++;
                    end
                    if (out_if.found_year !== want.found_year) begin
                        $error("found_year: expected %0d, got %0d",
                               want.found_year, out_if.found_year);
                        o_mismatches++;
                    end
                    if (out_if.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, out_if.entry_count);
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending = pending_res_q.size();
    end

endmodule

// ===== tb/record_stack_queue_with_search_core_tb.sv =====
`timescale 1ns / 1ps

module record_stack_queue_with_search_core_tb;
    import rsqs_pkg::*;

    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 210;
    localparam int QUIET_FIRST   = 900;
    localparam int QUIET_LAST    = 1200;
    localparam int HOLD_AT       = 250;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;
    int   mismatches;
    int   pending;
    int   items_sent;

    rsqs_in_if  op_if ();
    rsqs_out_if res_if ();

    record_stack_queue_with_search_core #(.DEPTH(DEPTH_DEF)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (op_if),
        .o_out         (res_if)
    );

    rsqs_result_check #(.DEPTH(DEPTH_DEF)) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .in_if         (op_if),
        .out_if        (res_if),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run limit, far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("record_stack_queue_with_search_core: mismatch");
        $finish;
    end

    // Keys drawn mostly from a small set so that searches hit and duplicates occur
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] key_set [12];
        key_set = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                    32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8};
        if ($urandom_range(99) < 70)
            return key_set[$urandom_range(11)];
        return $urandom;
    endfunction

    // Offers one operation and returns in the step of its transfer
    task automatic offer(t_op op, logic [KEY_W-1:0] key, logic [YEAR_W-1:0] year);
        bit quiet;
        quiet = (items_sent >= QUIET_FIRST) && (items_sent < QUIET_LAST);
        if (!quiet && $urandom_range(99) < 9) begin
            op_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        op_if.valid <= 1'b1;
        op_if.mode  <= op;
        op_if.key   <= key;
        op_if.year  <= year;
        do @(posedge i_clk); while (!op_if.ready);
        items_sent++;
    endtask

    // Stops offering and waits until every result is back and the block is idle
    task automatic quiesce();
        op_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(logic fifo);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= fifo;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Result side: random stalls, one long hold-off, and a stretch with none
    initial begin : result_sink
        int  taken;
        int  hold_left;
        bit  held_once;
        taken     = 0;
        hold_left = 0;
        held_once = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready)
                taken++;
            if (!held_once && taken == HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (taken >= QUIET_FIRST && taken < QUIET_LAST) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(99) >= 9);
            end
        end
    end

    // Stimulus
    initial begin
        logic fifo_seq [N_PHASES];
        int   roll;
        int   w_ins;
        int   w_rem;
        t_op  op;

        fifo_seq      = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        items_sent    = 0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        op_if.valid   <= 1'b0;
        op_if.mode    <= OP_NOP;
        op_if.key     <= '0;
        op_if.year    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mode(1'b0);

        // Directed: empty store, extremes, duplicate keys, stack order
        offer(OP_REMOVE, 32'd0, 16'd0);
        offer(OP_SEARCH, 32'd5, 16'd0);
        offer(OP_NOP,    32'h8000_0000, 16'hffff);
        offer(OP_INSERT, 32'h8000_0000, 16'h0000);
        offer(OP_INSERT, 32'h7fff_ffff, 16'hffff);
        offer(OP_INSERT, 32'h0, 16'd1234);
        offer(OP_INSERT, 32'hffff_ffff, 16'd7);
        offer(OP_INSERT, 32'h0, 16'd2024);
        offer(OP_SEARCH, 32'h0, 16'hffff);
        offer(OP_SEARCH, 32'h8000_0000, 16'd0);
        offer(OP_SEARCH, 32'h1234_5678, 16'd0);
        offer(OP_REMOVE, 32'h0, 16'd0);
        offer(OP_SEARCH, 32'h0, 16'd0);
        offer(OP_NOP,    32'hffff_ffff, 16'h0000);

        // Switch to queue order with records held: removes now take the oldest
        quiesce();
        write_mode(1'b1);
        offer(OP_REMOVE, 32'h0, 16'd0);
        offer(OP_SEARCH, 32'h8000_0000, 16'd0);
        offer(OP_INSERT, 32'd5, 16'd99);
        offer(OP_SEARCH, 32'hffff_ffff, 16'd0);
        offer(OP_REMOVE, 32'h0, 16'd0);
        offer(OP_NOP,    32'h5555_aaaa, 16'haaaa);

        // Random phases: filling, mixed and draining, in both orders
        for (int p = 0; p < N_PHASES; p++) begin
            quiesce();
            write_mode(fifo_seq[p]);
            case (p % 3)
                0: begin w_ins = 70; w_rem = 10; end
                1: begin w_ins = 35; w_rem = 30; end
                default: begin w_ins = 10; w_rem = 70; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(99);
                if (roll < w_ins)
                    op = OP_INSERT;
                else if (roll < w_ins + w_rem)
                    op = OP_REMOVE;
                else if (roll < 97)
                    op = OP_SEARCH;
                else
                    op = OP_NOP;
                offer(op, pick_key(), 16'($urandom));
            end
        end

        // Drain and give the verdict
        quiesce();
        if (mismatches == 0 && pending == 0)
            $display("record_stack_queue_with_search_core: match");
        else
            $display("record_stack_queue_with_search_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rsqs_pkg.sv
src/rsqs_if.sv
src/rsqs_store.sv
src/rsqs_ctrl.sv
src/record_stack_queue_with_search_core.sv
tb/rsqs_result_check.sv
tb/record_stack_queue_with_search_core_tb.sv
